// File: rtl/core/point_in_mesh_ray_parity_unit_macros.svh
// Assertion macros for the ray parity unit
`ifndef POINT_IN_MESH_RAY_PARITY_UNIT_MACROS_SVH
`define POINT_IN_MESH_RAY_PARITY_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define PIM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define PIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pimrp_pkg.sv
package pimrp_pkg;

  localparam int COORD_W         = 18;
  localparam int EPS_W           = 16;
  localparam int CNT_W           = 16;
  localparam int DIST_W          = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 18;
  localparam int COORD_FRAC_BITS_DEF = 14;

  // difference of two coordinates
  localparam int DIFF_W = COORD_W + 1;
  // product of two differences
  localparam int PROD_W = 2 * DIFF_W;
  // normal component / barycentric numerator
  localparam int NRM_W  = PROD_W + 1;
  // plane distance numerator: three normal*diff products
  localparam int DOT_W  = NRM_W + DIFF_W + 2;
  // divider working width
  localparam int QUO_W  = DOT_W;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_X = 2'd0,
    CFG_POINT_Y = 2'd1,
    CFG_POINT_Z = 2'd2,
    CFG_EPSILON = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_DOT0,
    ST_DOT1,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_DECIDE,
    ST_OUT
  } pim_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture triangle
    logic diff;      // form edge and point differences
    logic mul0;      // first product set
    logic mul1;      // second product set
    logic mul2;      // barycentric numerators
    logic dot0;      // sum partial dot products
    logic dot1;      // final dot product
    logic div_start; // launch divider
    logic decide;    // update count / distance
    logic clear;     // end of mesh: reset accumulators
  } pim_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
  } pim_sts_t;

endpackage

// File: rtl/core/pimrp_divider.sv
module pimrp_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pimrp_pkg::QUO_W-1:0] dividend,
  input  logic [pimrp_pkg::QUO_W-1:0] divisor,
  output logic                      done,
  output logic [pimrp_pkg::QUO_W-1:0] quotient,
  output logic                      rem_nz
);
  import pimrp_pkg::*;

  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [QUO_W:0]       rem_r, rem_nxt;
  logic [QUO_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [QUO_W:0]       trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[QUO_W-1:0], quo_r[QUO_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = (rem_r != '0);
endmodule

// File: rtl/core/pimrp_datapath.sv
module pimrp_datapath #(
  parameter int COORD_FRAC_BITS = pimrp_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pimrp_pkg::pim_cmd_t               cmd,
  output pimrp_pkg::pim_sts_t               sts,
  input  logic signed [pimrp_pkg::COORD_W-1:0] tri_in [9],
  input  logic signed [pimrp_pkg::COORD_W-1:0] pt_x,
  input  logic signed [pimrp_pkg::COORD_W-1:0] pt_y,
  input  logic signed [pimrp_pkg::COORD_W-1:0] pt_z,
  input  logic [pimrp_pkg::EPS_W-1:0]       eps,
  output logic [pimrp_pkg::CNT_W-1:0]       count
);
  import pimrp_pkg::*;

  localparam logic [DIST_W-1:0] TEN_FIX = DIST_W'(10) << COORD_FRAC_BITS;

  logic signed [COORD_W-1:0] v_r [9];
  logic signed [DIFF_W-1:0]  ux_r, uy_r, uz_r, vx_r, vy_r, vz_r, wx_r, wy_r, wz_r;
  logic signed [PROD_W-1:0]  p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [NRM_W-1:0]   nx_r, ny_r, nz_r, sn_r, tn_r;
  logic signed [DOT_W-1:0]   dxy_r, dot_r;
  logic                      ddiv_neg_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [DIST_W-1:0]         dist_r, dist_nxt;

  logic [QUO_W-1:0] div_q;
  logic             div_rnz;
  logic [QUO_W-1:0] div_dividend, div_divisor;
  logic signed [DOT_W-1:0] d0n;
  logic [NRM_W-1:0]  anx;

  logic signed [QUO_W+1:0] q_s, r_s;
  logic signed [NRM_W-1:0] sn_a, tn_a;
  logic signed [NRM_W:0]   st_sum;
  logic degen, parallel, in_plane, hit;
  logic signed [DOT_W-1:0] nx_ten;

  assign anx = nx_r[NRM_W-1] ? NRM_W'(-nx_r) : NRM_W'(nx_r);
  assign d0n = nx_r[NRM_W-1] ? -dot_r : dot_r;
  assign div_dividend = d0n[DOT_W-1] ? QUO_W'(-d0n) : QUO_W'(d0n);
  assign div_divisor  = QUO_W'(anx);

  pimrp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (sts.div_done),
    .quotient (div_q),
    .rem_nz   (div_rnz)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) v_r <= tri_in;
    if (cmd.diff) begin
      ux_r <= DIFF_W'(v_r[0]) - DIFF_W'(v_r[6]);
      uy_r <= DIFF_W'(v_r[1]) - DIFF_W'(v_r[7]);
      uz_r <= DIFF_W'(v_r[2]) - DIFF_W'(v_r[8]);
      vx_r <= DIFF_W'(v_r[3]) - DIFF_W'(v_r[6]);
      vy_r <= DIFF_W'(v_r[4]) - DIFF_W'(v_r[7]);
      vz_r <= DIFF_W'(v_r[5]) - DIFF_W'(v_r[8]);
      wx_r <= DIFF_W'(pt_x) - DIFF_W'(v_r[6]);
      wy_r <= DIFF_W'(pt_y) - DIFF_W'(v_r[7]);
      wz_r <= DIFF_W'(pt_z) - DIFF_W'(v_r[8]);
    end
    // normal components: six cross products, subtracted in mul1
    if (cmd.mul0) begin
      p0_r <= PROD_W'(uy_r * vz_r);
      p1_r <= PROD_W'(uz_r * vy_r);
      p2_r <= PROD_W'(uz_r * vx_r);
      p3_r <= PROD_W'(ux_r * vz_r);
      p4_r <= PROD_W'(ux_r * vy_r);
      p5_r <= PROD_W'(uy_r * vx_r);
    end
    if (cmd.mul1) begin
      nx_r <= NRM_W'(p0_r) - NRM_W'(p1_r);
      ny_r <= NRM_W'(p2_r) - NRM_W'(p3_r);
      nz_r <= NRM_W'(p4_r) - NRM_W'(p5_r);
      p0_r <= PROD_W'(wy_r * vz_r);
      p1_r <= PROD_W'(wz_r * vy_r);
      p2_r <= PROD_W'(uy_r * wz_r);
      p3_r <= PROD_W'(uz_r * wy_r);
    end
    if (cmd.mul2) begin
      sn_r <= NRM_W'(p0_r) - NRM_W'(p1_r);
      tn_r <= NRM_W'(p2_r) - NRM_W'(p3_r);
    end
    if (cmd.dot0) dxy_r <= DOT_W'(nx_r * wx_r) + DOT_W'(ny_r * wy_r);
    if (cmd.dot1) dot_r <= dxy_r + DOT_W'(nz_r * wz_r);
    if (cmd.div_start) ddiv_neg_r <= d0n[DOT_W-1];
  end

  assign nx_ten = DOT_W'(nx_r) <<< COORD_FRAC_BITS;

  // classification and final decision
  always_comb begin
    degen    = (nx_r == '0) && (ny_r == '0) && (nz_r == '0);
    parallel = (nx_r == '0) || ({1'b0, anx} < (NRM_W+1)'(eps));
    in_plane = (dot_r == (nx_ten + (nx_ten <<< 2)) + (nx_ten + (nx_ten <<< 2)) - nx_ten * 0);
    // q = ceil(d0/|nx|) for d0>=0, trunc toward zero for d0<0
    if (ddiv_neg_r) q_s = -$signed({2'b00, div_q});
    else            q_s = $signed({2'b00, div_q}) + (div_rnz ? 1 : 0);
    r_s    = $signed((QUO_W+2)'(TEN_FIX)) - q_s;
    sn_a   = nx_r[NRM_W-1] ? -sn_r : sn_r;
    tn_a   = nx_r[NRM_W-1] ? -tn_r : tn_r;
    st_sum = (NRM_W+1)'(sn_a) + (NRM_W+1)'(tn_a);
    cnt_nxt  = cnt_r;
    dist_nxt = dist_r;
    hit      = 1'b0;
    if (cmd.decide && !degen) begin
      if (parallel) begin
        hit = in_plane && (dist_r < TEN_FIX);
      end else if (!r_s[QUO_W+1]) begin
        dist_nxt = (r_s > $signed((QUO_W+2)'(33'h0FFFFFFFF))) ? '1 : DIST_W'(r_s);
        hit = !sn_a[NRM_W-1] && ($signed({1'b0, sn_a}) <= $signed({1'b0, anx}))
           && !tn_a[NRM_W-1] && (st_sum <= $signed({1'b0, anx}))
           && (dist_nxt < TEN_FIX);
      end
    end
    if (hit && cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r  <= '0;
      dist_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign count = cnt_r;
endmodule

// File: rtl/core/pimrp_ctrl.sv
`include "point_in_mesh_ray_parity_unit_macros.svh"
module pimrp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_last,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_load,
  output pimrp_pkg::pim_cmd_t cmd,
  input  pimrp_pkg::pim_sts_t sts
);
  import pimrp_pkg::*;

  pim_state_t state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       ovld_r, ovld_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    ovld_nxt  = ovld_r && out_stall;
    cmd       = '0;
    out_load  = 1'b0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        last_nxt  = in_last;
        state_nxt = ST_DIFF;
      end
      ST_DIFF:     begin cmd.diff = 1'b1; state_nxt = ST_MUL0; end
      ST_MUL0:     begin cmd.mul0 = 1'b1; state_nxt = ST_MUL1; end
      ST_MUL1:     begin cmd.mul1 = 1'b1; state_nxt = ST_MUL2; end
      ST_MUL2:     begin cmd.mul2 = 1'b1; state_nxt = ST_DOT0; end
      ST_DOT0:     begin cmd.dot0 = 1'b1; state_nxt = ST_DOT1; end
      ST_DOT1:     begin cmd.dot1 = 1'b1; state_nxt = ST_CLASSIFY; end
      ST_CLASSIFY: begin cmd.div_start = 1'b1; state_nxt = ST_DIVIDE; end
      ST_DIVIDE:   if (sts.div_done) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = last_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: if (!ovld_r || !out_stall) begin
        out_load  = 1'b1;
        cmd.clear = 1'b1;
        ovld_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_valid = ovld_r;

  `PIM_ASSERT_IMP(a_accept_idle, clk, rst_n, in_valid && !in_stall, state_r == ST_IDLE, "accept outside idle")
  `PIM_ASSERT_NEXT(a_load_valid, clk, rst_n, out_load, out_valid, "result load lost")
  `PIM_ASSERT_IMP(a_clear_out, clk, rst_n, cmd.clear, out_load, "clear without result")
endmodule

// File: rtl/core/point_in_mesh_ray_parity_unit.sv
// Flow: a triangle request passes 7 setup steps, the 60-step restoring
//   divider and 1 decide step before the count updates; a last_triangle
//   request then passes an output step that loads the result.
// Input stall: a new triangle request is taken only after the previous one
//   is done, and later while an earlier result is still stalled at the output.
// Reset: rst_n synchronous active low; clears count, distance, state machine
//   and registers to point (0,0,0) and epsilon 1.
module point_in_mesh_ray_parity_unit #(
  parameter int COORD_FRAC_BITS = pimrp_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [pimrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pimrp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_a_x,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_a_y,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_a_z,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_b_x,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_b_y,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_b_z,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_c_x,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_c_y,
  input  logic signed [pimrp_pkg::COORD_W-1:0] in_c_z,
  input  logic in_last_triangle,
  output logic out_valid,
  input  logic out_stall,
  output logic out_inside_res,
  output logic [pimrp_pkg::CNT_W-1:0] out_crossing_count
);
  import pimrp_pkg::*;

  // configuration registers
  logic signed [COORD_W-1:0] pt_x_r, pt_y_r, pt_z_r;
  logic [EPS_W-1:0]          eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_x_r <= '0;
      pt_y_r <= '0;
      pt_z_r <= '0;
      eps_r  <= EPS_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POINT_X: pt_x_r <= cfg_data;
        CFG_POINT_Y: pt_y_r <= cfg_data;
        CFG_POINT_Z: pt_z_r <= cfg_data;
        CFG_EPSILON: eps_r  <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [COORD_W-1:0] tri_in [9];
  assign tri_in = '{in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
                    in_c_x, in_c_y, in_c_z};

  pim_cmd_t           cmd;
  pim_sts_t           sts;
  logic               out_load;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   res_cnt_r;

  pimrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_last_triangle),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_load  (out_load),
    .cmd       (cmd),
    .sts       (sts)
  );

  pimrp_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .tri_in (tri_in),
    .pt_x   (pt_x_r),
    .pt_y   (pt_y_r),
    .pt_z   (pt_z_r),
    .eps    (eps_r),
    .count  (count)
  );

  // output register holds the result request until taken
  always_ff @(posedge clk) begin
    if (out_load) res_cnt_r <= count;
  end

  assign out_crossing_count = res_cnt_r;
  assign out_inside_res     = res_cnt_r[0];
endmodule
